// ----- hw/rtl/rgb2hsl_pkg.sv -----
`timescale 1ns / 1ps

package rgb2hsl_pkg;

    // Field widths of the stream words
    localparam int IN_BITS      = 8;
    localparam int OUT_BITS     = 15;

    // Channel datapath width and full scale
    localparam int CHANNEL_BITS = 8;
    localparam int CH_MAX       = (1 << CHANNEL_BITS) - 1;

    // Output scale factors: degrees*64 over one sixth of the circle, percent*256
    localparam int HUE_SCALE    = 3840;
    localparam int PCT_SCALE    = 25600;

    // Hue numerator term n is below 6*d
    localparam int N_BITS       = CHANNEL_BITS + 3;
    localparam int SUM_BITS     = CHANNEL_BITS + 1;

    // Dividend widths of the two variable divisions
    localparam int HUE_NUM_W    = $clog2(HUE_SCALE * 6 * CH_MAX + 1);
    localparam int SAT_NUM_W    = $clog2(PCT_SCALE * CH_MAX + 1);

    // Lightness divides by the constant 2*CH_MAX: multiply by a rounded-up
    // reciprocal; the shift keeps the error under one step for every sum
    localparam int     LIT_SHIFT   = 2 * CHANNEL_BITS + 2;
    localparam longint LIT_RECIP   = ((longint'(PCT_SCALE) << LIT_SHIFT)
                                     + longint'(2 * CH_MAX - 1)) / longint'(2 * CH_MAX);
    localparam int     LIT_RECIP_W = $clog2(LIT_RECIP + 1);
    localparam int     LIT_PROD_W  = SUM_BITS + LIT_RECIP_W;

    localparam logic [SUM_BITS-1:0] SUM_LIM = SUM_BITS'(CH_MAX);
    localparam logic [SUM_BITS-1:0] TWO_MAX = SUM_BITS'(2 * CH_MAX);

    typedef struct packed {
        logic [IN_BITS-1:0] red;
        logic [IN_BITS-1:0] green;
        logic [IN_BITS-1:0] blue;
    } t_rgb;

    typedef struct packed {
        logic [OUT_BITS-1:0] hue;
        logic [OUT_BITS-1:0] saturation;
        logic [OUT_BITS-1:0] lightness;
    } t_hsl;

    typedef enum logic [1:0] {
        MAX_RED,
        MAX_GREEN,
        MAX_BLUE
    } t_max_sel;

endpackage

// ----- hw/rtl/rgb2hsl_div.sv -----
`timescale 1ns / 1ps

// Restoring divider, one quotient bit per register stage.
// The quotient must fit in QUO_W bits.
module rgb2hsl_div #(
    parameter int NUM_W = rgb2hsl_pkg::HUE_NUM_W,
    parameter int DIV_W = rgb2hsl_pkg::CHANNEL_BITS,
    parameter int QUO_W = rgb2hsl_pkg::OUT_BITS
) (
    input  logic             i_clk,
    input  logic [QUO_W-1:0] i_en,
    input  logic [NUM_W-1:0] i_num,
    input  logic [DIV_W-1:0] i_div,
    output logic [QUO_W-1:0] o_quo
);

    logic [DIV_W-1:0] r_rem [QUO_W];
    logic [QUO_W-1:0] r_low [QUO_W];
    logic [QUO_W-1:0] r_quo [QUO_W];
    logic [DIV_W-1:0] r_dvs [QUO_W];

    for (genvar k = 0; k < QUO_W; k++) begin : g_stage
        logic [DIV_W-1:0] n_rem_in;
        logic [QUO_W-1:0] n_low_in;
        logic [QUO_W-1:0] n_quo_in;
        logic [DIV_W-1:0] n_dvs_in;
        logic [DIV_W:0]   n_trial;
        logic             n_ge;

        if (k == 0) begin : g_first
            assign n_rem_in = DIV_W'(i_num[NUM_W-1:QUO_W]);
            assign n_low_in = i_num[QUO_W-1:0];
            assign n_quo_in = '0;
            assign n_dvs_in = i_div;
        end else begin : g_next
            assign n_rem_in = r_rem[k-1];
            assign n_low_in = r_low[k-1];
            assign n_quo_in = r_quo[k-1];
            assign n_dvs_in = r_dvs[k-1];
        end

        // shift in the next dividend bit and try the subtraction
        assign n_trial = {n_rem_in, n_low_in[QUO_W-1]};
        assign n_ge    = (n_trial >= {1'b0, n_dvs_in});

        always_ff @(posedge i_clk) begin
            if (i_en[k]) begin
                r_rem[k] <= n_ge ? DIV_W'(n_trial - {1'b0, n_dvs_in}) : DIV_W'(n_trial);
                r_low[k] <= {n_low_in[QUO_W-2:0], 1'b0};
                r_quo[k] <= {n_quo_in[QUO_W-2:0], n_ge};
                r_dvs[k] <= n_dvs_in;
            end
        end
    end

    assign o_quo = r_quo[QUO_W-1];

endmodule

// ----- hw/rtl/rgb_to_hsl_converter.sv -----
`timescale 1ns / 1ps
// Pipeline: 19 register stages, 4 front stages plus one per quotient bit (15 bits).
// Throughput: one word per cycle while the output is not stalled, set by the fully
// pipelined bit-per-stage dividers.
// Each stage holds while the one after it is full and stalled; bubbles fill in.
// Reset: synchronous, active low; clears every stage valid bit, data is not reset.
module rgb_to_hsl_converter (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  rgb2hsl_pkg::t_rgb  i_rgb,
    output logic               o_valid,
    input  logic               i_ready,
    output rgb2hsl_pkg::t_hsl  o_hsl
);

    localparam int CB      = rgb2hsl_pkg::CHANNEL_BITS;
    localparam int QW      = rgb2hsl_pkg::OUT_BITS;
    localparam int NB      = rgb2hsl_pkg::N_BITS;
    localparam int SB      = rgb2hsl_pkg::SUM_BITS;
    localparam int HNW     = rgb2hsl_pkg::HUE_NUM_W;
    localparam int SNW     = rgb2hsl_pkg::SAT_NUM_W;
    localparam int LPW     = rgb2hsl_pkg::LIT_PROD_W;
    // Front stages: input, max/min, numerators, scaling products
    localparam int FRONT   = 4;
    localparam int STAGES  = FRONT + QW;

    // ------------------------------------------------------------------
    // Stage valid bits and the per-stage advance chain. A stage moves
    // when it is empty or the stage after it moves.
    // ------------------------------------------------------------------
    logic [STAGES-1:0] r_vld;
    logic [STAGES-1:0] w_en;

    always_comb begin
        w_en[STAGES-1] = !r_vld[STAGES-1] || i_ready;
        for (int j = STAGES - 2; j >= 0; j--) begin
            w_en[j] = !r_vld[j] || w_en[j+1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (w_en[0]) begin
                r_vld[0] <= i_valid;
            end
            for (int j = 1; j < STAGES; j++) begin
                if (w_en[j]) begin
                    r_vld[j] <= r_vld[j-1];
                end
            end
        end
    end

    assign o_ready = w_en[0];

    // ------------------------------------------------------------------
    // Stage 1: capture the pixel, masked to the channel width.
    // ------------------------------------------------------------------
    logic [CB-1:0] r_s1_r, r_s1_g, r_s1_b;

    always_ff @(posedge i_clk) begin
        if (w_en[0]) begin
            r_s1_r <= CB'(i_rgb.red);
            r_s1_g <= CB'(i_rgb.green);
            r_s1_b <= CB'(i_rgb.blue);
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: find max and min. Ties go to red, then green. Also pick the
    // two channels whose difference feeds the hue (n = base + a - c).
    // ------------------------------------------------------------------
    rgb2hsl_pkg::t_max_sel n_s2_sel;
    logic [CB-1:0]         n_s2_hi, n_s2_lo, n_s2_a, n_s2_c;

    always_comb begin
        if (r_s1_r >= r_s1_g && r_s1_r >= r_s1_b) begin
            n_s2_sel = rgb2hsl_pkg::MAX_RED;
            n_s2_hi  = r_s1_r;
            n_s2_a   = r_s1_g;
            n_s2_c   = r_s1_b;
        end else if (r_s1_g >= r_s1_b) begin
            n_s2_sel = rgb2hsl_pkg::MAX_GREEN;
            n_s2_hi  = r_s1_g;
            n_s2_a   = r_s1_b;
            n_s2_c   = r_s1_r;
        end else begin
            n_s2_sel = rgb2hsl_pkg::MAX_BLUE;
            n_s2_hi  = r_s1_b;
            n_s2_a   = r_s1_r;
            n_s2_c   = r_s1_g;
        end
        n_s2_lo = r_s1_r;
        if (r_s1_g < n_s2_lo) begin
            n_s2_lo = r_s1_g;
        end
        if (r_s1_b < n_s2_lo) begin
            n_s2_lo = r_s1_b;
        end
    end

    rgb2hsl_pkg::t_max_sel r_s2_sel;
    logic [CB-1:0]         r_s2_hi, r_s2_lo, r_s2_a, r_s2_c;

    always_ff @(posedge i_clk) begin
        if (w_en[1]) begin
            r_s2_sel <= n_s2_sel;
            r_s2_hi  <= n_s2_hi;
            r_s2_lo  <= n_s2_lo;
            r_s2_a   <= n_s2_a;
            r_s2_c   <= n_s2_c;
        end
    end

    // ------------------------------------------------------------------
    // Stage 3: chroma d, sum, hue numerator n and saturation divisor.
    // Red as max with green below blue wraps by a full circle (6d).
    // ------------------------------------------------------------------
    logic [CB-1:0] n_s3_d;
    logic [SB-1:0] n_s3_sum;
    logic [NB-1:0] n_s3_base, n_s3_n;
    logic [CB-1:0] n_s3_den;

    always_comb begin
        n_s3_d   = r_s2_hi - r_s2_lo;
        n_s3_sum = SB'(r_s2_hi) + SB'(r_s2_lo);
        unique case (r_s2_sel)
            rgb2hsl_pkg::MAX_RED: begin
                n_s3_base = (r_s2_a >= r_s2_c) ? '0
                          : (NB'(n_s3_d) << 2) + (NB'(n_s3_d) << 1);
            end
            rgb2hsl_pkg::MAX_GREEN: n_s3_base = NB'(n_s3_d) << 1;
            rgb2hsl_pkg::MAX_BLUE:  n_s3_base = NB'(n_s3_d) << 2;
            default:                n_s3_base = '0;
        endcase
        n_s3_n   = n_s3_base + NB'(r_s2_a) - NB'(r_s2_c);
        n_s3_den = (n_s3_sum <= rgb2hsl_pkg::SUM_LIM) ? CB'(n_s3_sum)
                 : CB'(rgb2hsl_pkg::TWO_MAX - n_s3_sum);
    end

    logic [NB-1:0] r_s3_n;
    logic [CB-1:0] r_s3_d, r_s3_den;
    logic [SB-1:0] r_s3_sum;
    logic          r_s3_gray;

    always_ff @(posedge i_clk) begin
        if (w_en[2]) begin
            r_s3_n    <= n_s3_n;
            r_s3_d    <= n_s3_d;
            r_s3_sum  <= n_s3_sum;
            r_s3_den  <= n_s3_den;
            r_s3_gray <= (n_s3_d == '0);
        end
    end

    // ------------------------------------------------------------------
    // Stage 4: scale the dividends by constant products. Lightness is
    // finished here: sum times the reciprocal of 2*max, then shift down.
    // ------------------------------------------------------------------
    logic [HNW-1:0] r_s4_hnum;
    logic [SNW-1:0] r_s4_snum;
    logic [QW-1:0]  r_s4_lit;
    logic [CB-1:0]  r_s4_d, r_s4_den;
    logic           r_s4_gray;
    logic [LPW-1:0] n_s4_lprod;

    assign n_s4_lprod = LPW'(r_s3_sum) * LPW'(rgb2hsl_pkg::LIT_RECIP);

    always_ff @(posedge i_clk) begin
        if (w_en[3]) begin
            r_s4_hnum <= HNW'(r_s3_n) * HNW'(rgb2hsl_pkg::HUE_SCALE);
            r_s4_snum <= SNW'(r_s3_d) * SNW'(rgb2hsl_pkg::PCT_SCALE);
            r_s4_lit  <= QW'(n_s4_lprod >> rgb2hsl_pkg::LIT_SHIFT);
            r_s4_d    <= r_s3_d;
            r_s4_den  <= r_s3_den;
            r_s4_gray <= r_s3_gray;
        end
    end

    // ------------------------------------------------------------------
    // Divider stages: two dividers in lockstep, one quotient bit each
    // stage. Gray pixels divide by zero; carry a flag to zero the result.
    // Lightness rides along the same stages.
    // ------------------------------------------------------------------
    logic [QW-1:0] w_hue_q, w_sat_q;
    logic [QW-1:0] r_gray;
    logic [QW-1:0] r_lit [QW];

    rgb2hsl_div #(
        .NUM_W (HNW),
        .DIV_W (CB),
        .QUO_W (QW)
    ) u_hue_div (
        .i_clk (i_clk),
        .i_en  (w_en[STAGES-1:FRONT]),
        .i_num (r_s4_hnum),
        .i_div (r_s4_d),
        .o_quo (w_hue_q)
    );

    rgb2hsl_div #(
        .NUM_W (SNW),
        .DIV_W (CB),
        .QUO_W (QW)
    ) u_sat_div (
        .i_clk (i_clk),
        .i_en  (w_en[STAGES-1:FRONT]),
        .i_num (r_s4_snum),
        .i_div (r_s4_den),
        .o_quo (w_sat_q)
    );

    always_ff @(posedge i_clk) begin
        if (w_en[FRONT]) begin
            r_gray[0] <= r_s4_gray;
            r_lit[0]  <= r_s4_lit;
        end
        for (int k = 1; k < QW; k++) begin
            if (w_en[FRONT+k]) begin
                r_gray[k] <= r_gray[k-1];
                r_lit[k]  <= r_lit[k-1];
            end
        end
    end

    // Output word comes straight from the last divider registers
    assign o_valid          = r_vld[STAGES-1];
    assign o_hsl.hue        = r_gray[QW-1] ? '0 : w_hue_q;
    assign o_hsl.saturation = r_gray[QW-1] ? '0 : w_sat_q;
    assign o_hsl.lightness  = r_lit[QW-1];

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_hue_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_hsl.hue < QW'(23040)))
        else $error("hue out of range");

    a_pct_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_hsl.saturation <= QW'(rgb2hsl_pkg::PCT_SCALE))
                 && (o_hsl.lightness <= QW'(rgb2hsl_pkg::PCT_SCALE)))
        else $error("saturation or lightness out of range");

    a_black: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_hsl.lightness == '0) |->
        (o_hsl.hue == '0 && o_hsl.saturation == '0))
        else $error("black pixel with nonzero hue or saturation");

    a_stall_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_ready |-> ((&r_vld) && !i_ready))
        else $error("input stalled while the pipeline has a bubble");

endmodule

// ----- tb/tb_rgb_to_hsl_converter.sv -----
`timescale 1ns / 1ps

module tb_rgb_to_hsl_converter;

    // Channel full scale and output scaling (degrees*64 per sixth, percent*256)
    localparam int FULL_SCALE   = 255;
    localparam int SIXTH_SCALE  = 3840;
    localparam int PERCENT_FIX  = 25600;
    // Pipeline depth is 19 stages; drain a little past it at the end
    localparam int DRAIN_CYCLES = 40;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int MAX_REPORTS  = 10;

    typedef struct {
        rgb2hsl_pkg::t_rgb pixel;
        rgb2hsl_pkg::t_hsl hsl;
    } t_hsl_expect;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_valid = 1'b0;
    logic i_ready = 1'b0;
    rgb2hsl_pkg::t_rgb i_rgb = '0;
    logic o_ready;
    logic o_valid;
    rgb2hsl_pkg::t_hsl o_hsl;

    t_hsl_expect pending_hsl[$];
    int          error_count   = 0;
    int          cycle_count   = 0;
    int          send_idle_pct = 0;
    int          stall_pct     = 0;
    int          stall_left    = 0;

    rgb_to_hsl_converter DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_rgb   (i_rgb),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_hsl   (o_hsl)
    );

    // 12 ns clock
    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
    end

    // Kill the run if the pipeline hangs
    initial begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // Idle length: mostly short, now and then a long stretch
    function automatic int rand_gap();
        if ($urandom_range(0, 9) < 8) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 40);
    endfunction

    // Compute the expected HSL word for one RGB word with exact integer math
    function automatic rgb2hsl_pkg::t_hsl predict_hsl(rgb2hsl_pkg::t_rgb px);
        int                    r, g, b;
        int                    hi, lo, span, sum, sixths, den;
        int                    hue_val, sat_val, lit_val;
        rgb2hsl_pkg::t_max_sel winner;
        rgb2hsl_pkg::t_hsl     res;
        r = int'(px.red);
        g = int'(px.green);
        b = int'(px.blue);
        // Ties go to red first, then green
        hi = r;
        winner = rgb2hsl_pkg::MAX_RED;
        if (g > hi) begin
            hi = g;
            winner = rgb2hsl_pkg::MAX_GREEN;
        end
        if (b > hi) begin
            hi = b;
            winner = rgb2hsl_pkg::MAX_BLUE;
        end
        lo = (g < r) ? g : r;
        lo = (b < lo) ? b : lo;
        span = hi - lo;
        sum  = hi + lo;
        lit_val = (PERCENT_FIX * sum) / (2 * FULL_SCALE);
        hue_val = 0;
        sat_val = 0;
        // Gray pixels keep hue and saturation at zero
        if (span != 0) begin
            case (winner)
                rgb2hsl_pkg::MAX_RED: begin
                    sixths = (g >= b) ? (g - b) : (6 * span - (b - g));
                end
                rgb2hsl_pkg::MAX_GREEN: begin
                    sixths = 2 * span + b - r;
                end
                default: begin
                    sixths = 4 * span + r - g;
                end
            endcase
            hue_val = (SIXTH_SCALE * sixths) / span;
            den = (sum <= FULL_SCALE) ? sum : (2 * FULL_SCALE - sum);
            sat_val = (den != 0) ? (PERCENT_FIX * span) / den : 0;
        end
        res.hue        = 15'(hue_val);
        res.saturation = 15'(sat_val);
        res.lightness  = 15'(lit_val);
        return res;
    endfunction

    // Pick a pixel: mostly uniform, with grays, channel ties and rail values mixed in
    function automatic rgb2hsl_pkg::t_rgb random_pixel();
        rgb2hsl_pkg::t_rgb px;
        byte unsigned rails[4];
        rails = '{8'd0, 8'd1, 8'd254, 8'd255};
        px.red   = 8'($urandom);
        px.green = 8'($urandom);
        px.blue  = 8'($urandom);
        case ($urandom_range(0, 9))
            0: begin
                px.green = px.red;
                px.blue  = px.red;
            end
            1: begin
                px.green = px.red;
            end
            2: begin
                if ($urandom_range(0, 1) == 0) begin
                    px.blue = px.green;
                end else begin
                    px.blue = px.red;
                end
            end
            3: begin
                px.red   = rails[$urandom_range(0, 3)];
                px.green = rails[$urandom_range(0, 3)];
                px.blue  = rails[$urandom_range(0, 3)];
            end
            default: begin
            end
        endcase
        return px;
    endfunction

    // Drive one word: maybe idle a random gap, then hold valid and payload until taken.
    // Leave valid high afterwards so back-to-back words need no second assignment.
    task automatic send_pixel(rgb2hsl_pkg::t_rgb px);
        int gap;
        t_hsl_expect entry;
        gap = 0;
        if ($urandom_range(0, 99) < send_idle_pct) begin
            gap = rand_gap();
        end
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_rgb   <= px;
        do begin
            @(posedge i_clk);
        end while (!o_ready);
        entry.pixel = px;
        entry.hsl   = predict_hsl(px);
        pending_hsl.push_back(entry);
    endtask

    // Receiver side: randomly drop ready for short or long stretches
    always @(posedge i_clk) begin
        if (stall_left > 0) begin
            i_ready <= 1'b0;
            stall_left--;
        end else if ($urandom_range(0, 99) < stall_pct) begin
            i_ready <= 1'b0;
            stall_left = rand_gap() - 1;
        end else begin
            i_ready <= 1'b1;
        end
    end

    // Compare each delivered word, field by field, against the oldest prediction
    always @(posedge i_clk) begin
        t_hsl_expect exp_word;
        if (i_rst_n && o_valid && i_ready) begin
            if (pending_hsl.size() == 0) begin
                if (error_count < MAX_REPORTS) begin
                    $display("unexpected word: hue %0d sat %0d lit %0d",
                             o_hsl.hue, o_hsl.saturation, o_hsl.lightness);
                end
                error_count++;
            end else begin
                exp_word = pending_hsl.pop_front();
                if (o_hsl.hue !== exp_word.hsl.hue
                        || o_hsl.saturation !== exp_word.hsl.saturation
                        || o_hsl.lightness !== exp_word.hsl.lightness) begin
                    if (error_count < MAX_REPORTS) begin
                        $display({"mismatch rgb (%0d,%0d,%0d): ",
                                  "exp h/s/l %0d/%0d/%0d got %0d/%0d/%0d"},
                                 exp_word.pixel.red, exp_word.pixel.green,
                                 exp_word.pixel.blue, exp_word.hsl.hue,
                                 exp_word.hsl.saturation, exp_word.hsl.lightness,
                                 o_hsl.hue, o_hsl.saturation, o_hsl.lightness);
                    end
                    error_count++;
                end
            end
        end
    end

    // Rails, primaries, secondaries, grays, max ties and the saturation fold point
    task automatic test_corner_pixels();
        send_idle_pct = 20;
        stall_pct     = 20;
        send_pixel({8'd0,   8'd0,   8'd0});
        send_pixel({8'd255, 8'd255, 8'd255});
        send_pixel({8'd128, 8'd128, 8'd128});
        send_pixel({8'd255, 8'd0,   8'd0});
        send_pixel({8'd0,   8'd255, 8'd0});
        send_pixel({8'd0,   8'd0,   8'd255});
        send_pixel({8'd255, 8'd255, 8'd0});
        send_pixel({8'd0,   8'd255, 8'd255});
        send_pixel({8'd255, 8'd0,   8'd255});
        send_pixel({8'd200, 8'd200, 8'd10});
        send_pixel({8'd10,  8'd200, 8'd200});
        send_pixel({8'd200, 8'd10,  8'd200});
        // Red on top with blue above green: hue wraps past 300 degrees
        send_pixel({8'd255, 8'd0,   8'd10});
        send_pixel({8'd255, 8'd10,  8'd0});
        // max + min right at full scale, then one above
        send_pixel({8'd200, 8'd55,  8'd55});
        send_pixel({8'd200, 8'd56,  8'd56});
        send_pixel({8'd1,   8'd0,   8'd0});
        send_pixel({8'd254, 8'd255, 8'd255});
        send_pixel({8'd170, 8'd85,  8'd170});
        send_pixel({8'd85,  8'd170, 8'd85});
        send_pixel({8'd128, 8'd64,  8'd200});
        send_pixel({8'd0,   8'd1,   8'd255});
    endtask

    task automatic test_random_pixels(int count, int idle_pct, int hold_pct);
        send_idle_pct = idle_pct;
        stall_pct     = hold_pct;
        repeat (count) begin
            send_pixel(random_pixel());
        end
    endtask

    // Send a burst, then hold off until the pipeline has handed back every word
    task automatic test_drain_pause(int bursts, int burst_len);
        send_idle_pct = 10;
        stall_pct     = 30;
        repeat (bursts) begin
            repeat (burst_len) begin
                send_pixel(random_pixel());
            end
            i_valid <= 1'b0;
            wait (pending_hsl.size() == 0);
            @(posedge i_clk);
        end
    endtask

    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_corner_pixels();
        test_random_pixels(500, 20, 20);
        // Full rate stretch: no idling on either side
        test_random_pixels(300, 0, 0);
        // Heavy backpressure so the pipeline fills and holds
        test_random_pixels(250, 10, 60);
        test_drain_pause(5, 60);

        i_valid <= 1'b0;
        wait (pending_hsl.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (pending_hsl.size() != 0) begin
            error_count++;
        end

        if (error_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
hw/rtl/rgb2hsl_pkg.sv
hw/rtl/rgb2hsl_div.sv
hw/rtl/rgb_to_hsl_converter.sv
tb/tb_rgb_to_hsl_converter.sv
